[src/rdiv_pkg.sv]
// Shared constants and types for the pipelined restoring divider.
`timescale 1ns / 1ps
package rdiv_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 64;
	localparam int unsigned FIELD_W        = 64;
	localparam int unsigned MODE_W         = 2;
	localparam int unsigned IN_TDATA_W     = 2 * FIELD_W;
	localparam int unsigned OUT_TDATA_W    = FIELD_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_UQUO = 2'd0,
		MODE_UREM = 2'd1,
		MODE_SQUO = 2'd2,
		MODE_SREM = 2'd3
	} mode_t;

	// Control that travels down the pipeline beside each word.
	typedef struct packed {
		logic valid;
		logic sel_rem;
		logic neg;
		logic zero;
	} ctrl_t;

endpackage

[src/rdiv_prep.sv]
// Input stage: operand trimming, sign handling and divisor zero check.
`timescale 1ns / 1ps
module rdiv_prep
	import rdiv_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [FIELD_W-1:0]    dividend,
	input  logic [FIELD_W-1:0]    divisor,
	input  logic [MODE_W-1:0]     mode,
	output ctrl_t                 ctrl_s1,
	output logic [DATA_WIDTH-1:0] num_s1,
	output logic [DATA_WIDTH-1:0] den_s1
);

	localparam int unsigned W = DATA_WIDTH;

	logic [W-1:0] num;
	logic [W-1:0] den;
	logic         is_signed;
	logic         num_neg;
	logic         den_neg;
	ctrl_t        ctrl_d;

	always_comb begin
		num       = dividend[W-1:0];
		den       = divisor[W-1:0];
		is_signed = (mode == MODE_SQUO) || (mode == MODE_SREM);
		num_neg   = is_signed & num[W-1];
		den_neg   = is_signed & den[W-1];
		ctrl_d.valid   = in_valid;
		ctrl_d.sel_rem = (mode == MODE_UREM) || (mode == MODE_SREM);
		ctrl_d.zero    = (den == '0);
		// The remainder follows the dividend's sign, the quotient the sign product.
		ctrl_d.neg     = (mode == MODE_SREM) ? num_neg : (num_neg ^ den_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= num_neg ? (~num + W'(1)) : num;
			den_s1 <= den_neg ? (~den + W'(1)) : den;
		end
	end

endmodule

[src/rdiv_round.sv]
// One restoring shift-and-subtract round with its pipeline register.
`timescale 1ns / 1ps
module rdiv_round
	import rdiv_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  ctrl_t                 ctrl_in,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] quo_in,
	input  logic [DATA_WIDTH-1:0] den_in,
	output ctrl_t                 ctrl_s1,
	output logic [DATA_WIDTH-1:0] rem_s1,
	output logic [DATA_WIDTH-1:0] quo_s1,
	output logic [DATA_WIDTH-1:0] den_s1
);

	localparam int unsigned W = DATA_WIDTH;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         fits;
	logic [W-1:0] rem_d;
	logic [W-1:0] quo_d;

	// The quotient register starts as the dividend: its top bit feeds the
	// partial remainder while the new quotient bit enters at the bottom.
	always_comb begin
		trial = {rem_in, quo_in[W-1]};
		diff  = trial - {1'b0, den_in};
		fits  = (trial >= {1'b0, den_in});
		rem_d = fits ? diff[W-1:0] : trial[W-1:0];
		quo_d = {quo_in[W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1 <= rem_d;
			quo_s1 <= quo_d;
			den_s1 <= den_in;
		end
	end

endmodule

[src/rdiv_post.sv]
// Output stage: result select, sign fix-up and the output register.
`timescale 1ns / 1ps
module rdiv_post
	import rdiv_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  ctrl_t                  ctrl_in,
	input  logic [DATA_WIDTH-1:0]  rem_in,
	input  logic [DATA_WIDTH-1:0]  quo_in,
	output logic                   out_valid,
	output logic [OUT_TDATA_W-1:0] out_data
);

	localparam int unsigned W = DATA_WIDTH;

	logic [W-1:0] pick;
	logic [W-1:0] res;

	always_comb begin
		pick = ctrl_in.sel_rem ? rem_in : quo_in;
		res  = ctrl_in.neg ? (~pick + W'(1)) : pick;
		if (ctrl_in.zero) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= OUT_TDATA_W'(res);
		end
	end

endmodule

[src/restoring_divider_64_top.sv]
// Top level of the pipelined signed/unsigned restoring divider.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: dividend, divisor; tuser: mode
//  m_*       out  m_tvalid/m_tready  tdata: result
//
// One word enters every cycle while the output does not stall. The depth is
// set by one shift-and-subtract round per pipeline stage, with
// one stage in front for magnitudes and one behind for sign and select.
// Reset clears only control state. When m_tready is low with a word waiting,
// every stage holds and s_tready drops, so nothing is lost or repeated.
`timescale 1ns / 1ps
module restoring_divider_64_top
	import rdiv_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // dividend[63:0], divisor[127:64]
	input  logic [MODE_W-1:0]      s_tuser,   // mode[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // result[63:0]
);

	localparam int unsigned W = DATA_WIDTH;

	logic         adv;
	ctrl_t        ctrl_c [0:W];
	logic [W-1:0] rem_c  [0:W];
	logic [W-1:0] quo_c  [0:W];
	logic [W-1:0] den_c  [0:W];

	// The whole pipeline moves whenever the output register is free.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign rem_c[0] = '0;

	rdiv_prep #(
		.DATA_WIDTH(W)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(s_tvalid),
		.dividend(s_tdata[FIELD_W-1:0]),
		.divisor (s_tdata[IN_TDATA_W-1:FIELD_W]),
		.mode    (s_tuser),
		.ctrl_s1 (ctrl_c[0]),
		.num_s1  (quo_c[0]),
		.den_s1  (den_c[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_round
		rdiv_round #(
			.DATA_WIDTH(W)
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctrl_in(ctrl_c[i]),
			.rem_in (rem_c[i]),
			.quo_in (quo_c[i]),
			.den_in (den_c[i]),
			.ctrl_s1(ctrl_c[i+1]),
			.rem_s1 (rem_c[i+1]),
			.quo_s1 (quo_c[i+1]),
			.den_s1 (den_c[i+1])
		);
	end

	rdiv_post #(
		.DATA_WIDTH(W)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctrl_in  (ctrl_c[W]),
		.rem_in   (rem_c[W]),
		.quo_in   (quo_c[W]),
		.out_valid(m_tvalid),
		.out_data (m_tdata)
	);

endmodule
